/* rtl/core/hrrn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the response-ratio scheduler.
// Used by every module under rtl/core; depends on nothing.
package hrrn_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W     = $clog2(MAX_PROCS);
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    localparam int CMD_W   = 2;
    localparam int ID_W    = 16;
    localparam int REQ_W   = 16;
    localparam int RUN_W   = 17;
    localparam int WAIT_W  = 24;
    localparam int RTIME_W = 16;
    localparam int SLICE_W = 4;
    localparam int STAT_W  = 3;
    localparam int ACT_W   = 5;
    localparam int PROD_W  = WAIT_W + REQ_W;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CMD_W-1:0]   CMD_ADD     = 2'd0;
    localparam logic [CMD_W-1:0]   CMD_RUN     = 2'd1;
    localparam logic [ADDR_W-1:0]  ADDR_SLICE  = 3'd0;
    localparam logic [SLICE_W-1:0] SLICE_RESET = 4'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_ADDED   = 3'd0,
        ST_RAN     = 3'd1,
        ST_FULL    = 3'd2,
        ST_ZERO    = 3'd3,
        ST_EMPTY   = 3'd4,
        ST_CLEARED = 3'd5
    } t_status;

    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [REQ_W-1:0]  req;
        logic [RUN_W-1:0]  run;
        logic [WAIT_W-1:0] wait_t;
    } t_entry;

    typedef struct packed {
        logic              add;
        logic              set_run;
        logic              set_wait;
        logic              kill;
        logic              clr_all;
        logic [IDX_W-1:0]  idx;
        logic [ID_W-1:0]   id;
        logic [REQ_W-1:0]  req;
        logic [RUN_W-1:0]  run;
        logic [WAIT_W-1:0] wait_t;
    } t_tbl_wr;

    typedef struct packed {
        logic ld_a;
        logic ld_b;
    } t_mac_op;

endpackage

/* rtl/core/hrrn_table.sv */
`timescale 1ns / 1ps
// Process table: valid bits plus id, required, run and wait fields per entry.
// One write port and one read index. Depends on hrrn_pkg.
module hrrn_table import hrrn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tbl_wr          i_wr,
    input  logic [IDX_W-1:0] i_rd_idx,
    output t_entry           o_rd
);

    logic [MAX_PROCS-1:0] r_valid;
    logic [ID_W-1:0]      r_id   [MAX_PROCS];
    logic [REQ_W-1:0]     r_req  [MAX_PROCS];
    logic [RUN_W-1:0]     r_run  [MAX_PROCS];
    logic [WAIT_W-1:0]    r_wait [MAX_PROCS];

    always_ff @(posedge i_clk) begin
        if (i_wr.add) begin
            r_id[i_wr.idx]   <= i_wr.id;
            r_req[i_wr.idx]  <= i_wr.req;
            r_run[i_wr.idx]  <= '0;
            r_wait[i_wr.idx] <= '0;
        end
        if (i_wr.set_run) begin
            r_run[i_wr.idx] <= i_wr.run;
        end
        if (i_wr.set_wait) begin
            r_wait[i_wr.idx] <= i_wr.wait_t;
        end
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.clr_all) begin
            r_valid <= '0;
        end else begin
            if (i_wr.add) begin
                r_valid[i_wr.idx] <= 1'b1;
            end
            if (i_wr.kill) begin
                r_valid[i_wr.idx] <= 1'b0;
            end
        end
    end

    assign o_rd.valid  = r_valid[i_rd_idx];
    assign o_rd.id     = r_id[i_rd_idx];
    assign o_rd.req    = r_req[i_rd_idx];
    assign o_rd.run    = r_run[i_rd_idx];
    assign o_rd.wait_t = r_wait[i_rd_idx];

endmodule

/* rtl/core/hrrn_mac.sv */
`timescale 1ns / 1ps
// Shared cross-product unit: one 24x16 multiplier whose product is captured
// into either of two registers, and a compare of the two. Depends on hrrn_pkg.
module hrrn_mac import hrrn_pkg::*; (
    input  logic              i_clk,
    input  t_mac_op           i_op,
    input  logic [WAIT_W-1:0] i_a,
    input  logic [REQ_W-1:0]  i_b,
    output logic              o_gt
);

    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] r_pa;
    logic [PROD_W-1:0] r_pb;

    assign w_prod = PROD_W'(i_a) * PROD_W'(i_b);

    always_ff @(posedge i_clk) begin
        if (i_op.ld_a) begin
            r_pa <= w_prod;
        end
        if (i_op.ld_b) begin
            r_pb <= w_prod;
        end
    end

    assign o_gt = (r_pa > r_pb);

endmodule

/* rtl/core/hrrn_seq.sv */
`timescale 1ns / 1ps
// Command sequencer: decodes a request, scans the table for the best ratio,
// sweeps it to apply the slice, and holds the result register. Depends on hrrn_pkg.
module hrrn_seq import hrrn_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_valid,
    output logic               o_s_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [ID_W-1:0]    i_pid,
    input  logic [REQ_W-1:0]   i_req,
    output logic               o_m_valid,
    input  logic               i_m_ready,
    output t_status            o_m_status,
    output logic [ID_W-1:0]    o_m_id,
    output logic [RTIME_W-1:0] o_m_time,
    output logic               o_m_fin,
    output logic [ACT_W-1:0]   o_m_act,
    input  logic [SLICE_W-1:0] i_slice,
    output t_tbl_wr            o_tbl_wr,
    output logic [IDX_W-1:0]   o_rd_idx,
    input  t_entry             i_rd,
    output t_mac_op            o_mac_op,
    output logic [WAIT_W-1:0]  o_mac_a,
    output logic [REQ_W-1:0]   o_mac_b,
    input  logic               i_gt
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MULB,
        S_CMP,
        S_UPD,
        S_DONE
    } t_state;

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_PROCS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_PROCS);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_found, n_found;
    logic [IDX_W-1:0]     r_best, n_best;
    logic [WAIT_W-1:0]    r_best_wait, n_best_wait;
    logic [REQ_W-1:0]     r_best_req, n_best_req;
    logic [CNT_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]     r_act, n_act;
    t_status              r_res_status, n_res_status;
    logic [ID_W-1:0]      r_res_id, n_res_id;
    logic [RTIME_W-1:0]   r_res_time, n_res_time;
    logic                 r_res_fin, n_res_fin;
    logic                 r_m_valid, n_m_valid;
    t_status              r_m_status, n_m_status;
    logic [ID_W-1:0]      r_m_id, n_m_id;
    logic [RTIME_W-1:0]   r_m_time, n_m_time;
    logic                 r_m_fin, n_m_fin;
    logic [CNT_W-1:0]     r_m_act, n_m_act;

    logic                 w_last;
    logic [RUN_W-1:0]     w_run_sum;
    logic [WAIT_W:0]      w_wait_sum;
    logic [WAIT_W-1:0]    w_wait_sat;

    assign w_last     = (r_idx == IDX_LAST);
    assign w_run_sum  = i_rd.run + RUN_W'(i_slice);
    assign w_wait_sum = {1'b0, i_rd.wait_t} + (WAIT_W + 1)'(i_slice);
    assign w_wait_sat = w_wait_sum[WAIT_W] ? '1 : w_wait_sum[WAIT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_found      = r_found;
        n_best       = r_best;
        n_best_wait  = r_best_wait;
        n_best_req   = r_best_req;
        n_fill       = r_fill;
        n_act        = r_act;
        n_res_status = r_res_status;
        n_res_id     = r_res_id;
        n_res_time   = r_res_time;
        n_res_fin    = r_res_fin;
        n_m_valid    = r_m_valid;
        n_m_status   = r_m_status;
        n_m_id       = r_m_id;
        n_m_time     = r_m_time;
        n_m_fin      = r_m_fin;
        n_m_act      = r_m_act;
        o_tbl_wr     = '0;
        o_tbl_wr.idx = r_idx;
        o_mac_op     = '0;
        o_mac_a      = i_rd.wait_t;
        o_mac_b      = r_best_req;

        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    n_res_id   = '0;
                    n_res_time = '0;
                    n_res_fin  = 1'b0;
                    n_state    = S_DONE;
                    if (i_cmd[1]) begin
                        o_tbl_wr.clr_all = 1'b1;
                        n_fill           = '0;
                        n_act            = '0;
                        n_res_status     = ST_CLEARED;
                    end else if (i_cmd == CMD_ADD) begin
                        if (i_req == '0) begin
                            n_res_status = ST_ZERO;
                        end else if (r_fill == CNT_FULL) begin
                            n_res_status = ST_FULL;
                        end else begin
                            o_tbl_wr.add = 1'b1;
                            o_tbl_wr.idx = r_fill[IDX_W-1:0];
                            o_tbl_wr.id  = i_pid;
                            o_tbl_wr.req = i_req;
                            n_fill       = r_fill + CNT_ONE;
                            n_act        = r_act + CNT_ONE;
                            n_res_status = ST_ADDED;
                        end
                    end else if (r_act == '0) begin
                        n_res_status = ST_EMPTY;
                    end else begin
                        n_res_status = ST_RAN;
                        n_idx        = '0;
                        n_found      = 1'b0;
                        n_state      = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                if (i_rd.valid && r_found) begin
                    // first product: wait of candidate times required of best
                    o_mac_op.ld_a = 1'b1;
                    n_state       = S_MULB;
                end else begin
                    if (i_rd.valid) begin
                        n_found     = 1'b1;
                        n_best      = r_idx;
                        n_best_wait = i_rd.wait_t;
                        n_best_req  = i_rd.req;
                    end
                    n_idx = w_last ? '0 : r_idx + 1'b1;
                    if (w_last) begin
                        n_state = S_UPD;
                    end
                end
            end

            S_MULB: begin
                o_mac_a       = r_best_wait;
                o_mac_b       = i_rd.req;
                o_mac_op.ld_b = 1'b1;
                n_state       = S_CMP;
            end

            S_CMP: begin
                // strict compare keeps the earlier entry on a tie
                if (i_gt) begin
                    n_best      = r_idx;
                    n_best_wait = i_rd.wait_t;
                    n_best_req  = i_rd.req;
                end
                n_idx   = w_last ? '0 : r_idx + 1'b1;
                n_state = w_last ? S_UPD : S_SCAN;
            end

            S_UPD: begin
                if (i_rd.valid) begin
                    if (r_idx == r_best) begin
                        o_tbl_wr.set_run = 1'b1;
                        o_tbl_wr.run     = w_run_sum;
                        n_res_id         = i_rd.id;
                        n_res_time       = w_run_sum[RUN_W-1] ? '1 : w_run_sum[RTIME_W-1:0];
                        if (w_run_sum >= RUN_W'(i_rd.req)) begin
                            o_tbl_wr.kill = 1'b1;
                            n_res_fin     = 1'b1;
                            n_act         = r_act - CNT_ONE;
                            if (r_act == CNT_ONE) begin
                                n_fill = '0;
                            end
                        end
                    end else begin
                        o_tbl_wr.set_wait = 1'b1;
                        o_tbl_wr.wait_t   = w_wait_sat;
                    end
                end
                n_idx   = w_last ? '0 : r_idx + 1'b1;
                n_state = w_last ? S_DONE : S_UPD;
            end

            S_DONE: begin
                // hold until the result register is free
                if (!r_m_valid || i_m_ready) begin
                    n_m_valid  = 1'b1;
                    n_m_status = r_res_status;
                    n_m_id     = r_res_id;
                    n_m_time   = r_res_time;
                    n_m_fin    = r_res_fin;
                    n_m_act    = r_act;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_best_wait  <= n_best_wait;
        r_best_req   <= n_best_req;
        r_best       <= n_best;
        r_res_status <= n_res_status;
        r_res_id     <= n_res_id;
        r_res_time   <= n_res_time;
        r_res_fin    <= n_res_fin;
        r_m_status   <= n_m_status;
        r_m_id       <= n_m_id;
        r_m_time     <= n_m_time;
        r_m_fin      <= n_m_fin;
        r_m_act      <= n_m_act;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_idx     <= '0;
            r_found   <= 1'b0;
            r_fill    <= '0;
            r_act     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_found   <= n_found;
            r_fill    <= n_fill;
            r_act     <= n_act;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_s_ready  = (r_state == S_IDLE);
    assign o_rd_idx   = r_idx;
    assign o_m_valid  = r_m_valid;
    assign o_m_status = r_m_status;
    assign o_m_id     = r_m_id;
    assign o_m_time   = r_m_time;
    assign o_m_fin    = r_m_fin;
    assign o_m_act    = ACT_W'(r_m_act);

endmodule

/* rtl/core/hrrn_process_scheduler.sv */
`timescale 1ns / 1ps
// Response-ratio scheduler top: stream in/out, config register, sequencer.
// Add and clear requests go straight to the done state; the result is registered
// once the output register is free. Run requests scan the table, using the shared
// 24x16 multiplier twice per compared entry, then sweep the table once.
// One request at a time; the next is taken once the current result is registered.
// Synchronous active-low reset empties the table and sets time_slice to 2.
module hrrn_process_scheduler import hrrn_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [31:0]       i_s_tdata,   // process_id, required_time
    input  logic [CMD_W-1:0]  i_s_tuser,   // command
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [39:0]       o_m_tdata,   // run_id, run_time_after, finished, active_left, pad
    output logic [STAT_W-1:0] o_m_tuser,   // status
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [SLICE_W-1:0] r_slice;
    t_tbl_wr            w_tbl_wr;
    logic [IDX_W-1:0]   w_rd_idx;
    t_entry             w_rd;
    t_mac_op            w_mac_op;
    logic [WAIT_W-1:0]  w_mac_a;
    logic [REQ_W-1:0]   w_mac_b;
    logic               w_gt;
    t_status            w_status;
    logic [ID_W-1:0]    w_id;
    logic [RTIME_W-1:0] w_time;
    logic               w_fin;
    logic [ACT_W-1:0]   w_act;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slice <= SLICE_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_SLICE)) begin
            r_slice <= pwdata[SLICE_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SLICE) ? DATA_W'(r_slice) : '0;

    hrrn_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_tbl_wr),
        .i_rd_idx (w_rd_idx),
        .o_rd     (w_rd)
    );

    hrrn_mac u_mac (
        .i_clk (i_clk),
        .i_op  (w_mac_op),
        .i_a   (w_mac_a),
        .i_b   (w_mac_b),
        .o_gt  (w_gt)
    );

    hrrn_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_tvalid),
        .o_s_ready  (o_s_tready),
        .i_cmd      (i_s_tuser),
        .i_pid      (i_s_tdata[15:0]),
        .i_req      (i_s_tdata[31:16]),
        .o_m_valid  (o_m_tvalid),
        .i_m_ready  (i_m_tready),
        .o_m_status (w_status),
        .o_m_id     (w_id),
        .o_m_time   (w_time),
        .o_m_fin    (w_fin),
        .o_m_act    (w_act),
        .i_slice    (r_slice),
        .o_tbl_wr   (w_tbl_wr),
        .o_rd_idx   (w_rd_idx),
        .i_rd       (w_rd),
        .o_mac_op   (w_mac_op),
        .o_mac_a    (w_mac_a),
        .o_mac_b    (w_mac_b),
        .i_gt       (w_gt)
    );

    assign o_m_tdata = {2'b00, w_act, w_fin, w_time, w_id};
    assign o_m_tuser = w_status;

endmodule

/* rtl/core/hrrn_chk.sv */
`timescale 1ns / 1ps
// Port-level checks for the scheduler top, attached by bind.
// Depends on hrrn_pkg and hrrn_process_scheduler.
module hrrn_chk import hrrn_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_tvalid,
    input logic              o_s_tready,
    input logic              o_m_tvalid,
    input logic              i_m_tready,
    input logic [39:0]       o_m_tdata,
    input logic [STAT_W-1:0] o_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result changed while stalled");

    // the block is busy in the cycle after it takes a request
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request taken back to back");

    a_added_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser == ST_ADDED)) |-> (o_m_tdata[37:33] != '0))
        else $error("added request left no active process");

    // no slice ran: id, time and finished flag read zero
    a_no_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tuser != ST_RAN)) |-> (o_m_tdata[32:0] == '0))
        else $error("run fields set without a slice");

endmodule

bind hrrn_process_scheduler hrrn_chk u_hrrn_chk (.*);
